// ===== rtl/core/ttl_cache_pkg.sv =====
// Package: shared constants and types for the TTL answer cache.
`timescale 1ns / 1ps
package ttl_cache_pkg;
	localparam int ENTRIES_DEF = 16;
	localparam int RECORDS_DEF = 8;
	localparam int RECORD_BITS_DEF = 64;
	localparam int KEY_BITS = 64;
	localparam int TYPE_BITS = 16;
	localparam int TIME_BITS = 32;
	localparam int EXP_BITS = 33;

	typedef enum logic [1:0] {
		FUNC_STORE_POS = 2'd0,
		FUNC_STORE_NEG = 2'd1,
		FUNC_LOOKUP    = 2'd2,
		FUNC_NONE      = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_INV,
		ST_SCAN_EXP,
		ST_SCAN_MIN,
		ST_START,
		ST_APPEND,
		ST_LK_SCAN,
		ST_LK_READ,
		ST_LK_WAIT,
		ST_EMIT
	} state_t;
endpackage

// ===== rtl/core/ttl_answer_cache_top.sv =====
// Top level: TTL answer cache with serial slot choice and lookup scan.
`timescale 1ns / 1ps
// Starting an entry runs the slot choice scans, ST_START and ST_APPEND between acceptance and ready
//   (serial slot choice, one entry per cycle); an append runs ST_APPEND alone.
// A lookup scans one entry per cycle (up to ENTRIES), then reads each record via ST_LK_READ and ST_LK_WAIT;
//   results leave via an output register that must drain before tready rises again.
// Throughput: one request at a time; tready is low while a request is in work.
// Reset (arst_n low, async): entries invalid, fill slot 0, output empty; no memory clear.
module ttl_answer_cache_top #(
	parameter int ENTRIES = ttl_cache_pkg::ENTRIES_DEF,
	parameter int RECORDS_PER_ENTRY = ttl_cache_pkg::RECORDS_DEF,
	parameter int RECORD_BITS = ttl_cache_pkg::RECORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata from bit 0: func(2) name_key(64) query_type(16) now_seconds(32) ttl(32)
	//   record_data(RECORD_BITS) first(1) soa_present(1), zero filled to bytes
	input  logic [((148+RECORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata from bit 0: hit(1) nxdomain(1) record_valid(1) record_out(RECORD_BITS)
	//   remaining_ttl(32), zero filled to bytes
	output logic [((35+RECORD_BITS+7)/8)*8-1:0] m_tdata,
	output logic m_tlast
);
	localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(RECORDS_PER_ENTRY + 1);
	localparam int MW = $clog2(ENTRIES * RECORDS_PER_ENTRY);
	localparam int MD = ENTRIES * RECORDS_PER_ENTRY;
	localparam int KB = ttl_cache_pkg::KEY_BITS;
	localparam int TB = ttl_cache_pkg::TYPE_BITS;
	localparam int NB = ttl_cache_pkg::TIME_BITS;
	localparam int EB = ttl_cache_pkg::EXP_BITS;
	localparam int OW = ((35+RECORD_BITS+7)/8)*8;

	// unpacked request fields
	ttl_cache_pkg::func_t in_func;
	logic [KB-1:0] in_key;
	logic [TB-1:0] in_type;
	logic [NB-1:0] in_now, in_ttl;
	logic [RECORD_BITS-1:0] in_data;
	logic in_first, in_soa;
	assign in_func  = ttl_cache_pkg::func_t'(s_tdata[1:0]);
	assign in_key   = s_tdata[65:2];
	assign in_type  = s_tdata[81:66];
	assign in_now   = s_tdata[113:82];
	assign in_ttl   = s_tdata[145:114];
	assign in_data  = s_tdata[146+RECORD_BITS-1:146];
	assign in_first = s_tdata[146+RECORD_BITS];
	assign in_soa   = s_tdata[147+RECORD_BITS];

	// latched request
	ttl_cache_pkg::func_t func_q;
	logic [KB-1:0] key_q;
	logic [TB-1:0] type_q;
	logic [NB-1:0] now_q, ttl_q;
	logic [RECORD_BITS-1:0] data_q;
	logic first_q, soa_q;

	// entry table (flop arrays, read at the scan index, the best slot and the append slot)
	logic [ENTRIES-1:0] valid_q;
	logic [KB-1:0] ekey_q [ENTRIES];
	logic [TB-1:0] etype_q [ENTRIES];
	logic [EB-1:0] eexp_q [ENTRIES];
	logic [ENTRIES-1:0] eneg_q, esoa_q;
	logic [CW-1:0] ecnt_q [ENTRIES];
	logic [SW-1:0] fill_q;

	// record memory
	logic [RECORD_BITS-1:0] mem [MD];
	logic [RECORD_BITS-1:0] rd_q;
	logic mem_we;
	logic [MW-1:0] mem_wa, mem_ra;
	logic [RECORD_BITS-1:0] mem_wd;

	ttl_cache_pkg::state_t state_q, state_d;
	logic [SW-1:0] idx_q, best_q, slot_q;
	logic [CW-1:0] rec_q, n_q;
	logic [EB-1:0] rem_q;

	// output register
	logic ov_q, o_hit_q, o_nx_q, o_rv_q, o_last_q;
	logic [RECORD_BITS-1:0] o_rec_q;
	logic [NB-1:0] o_rem_q;

	logic idx_end;
	logic exp_le;      // shared compare: expiry of idx <= now
	logic min_lt;      // expiry of idx < expiry of best
	logic match;
	logic o_load;      // output register takes a new result
	logic [EB-1:0] cur_exp, diff;
	assign idx_end = (idx_q == SW'(ENTRIES-1));
	assign cur_exp = eexp_q[idx_q];
	assign diff    = cur_exp - {1'b0, now_q};
	assign exp_le  = !(cur_exp > {1'b0, now_q});
	assign min_lt  = cur_exp < eexp_q[best_q];
	assign match   = valid_q[idx_q] && etype_q[idx_q] == type_q && ekey_q[idx_q] == key_q;
	assign o_load  = (state_q == ttl_cache_pkg::ST_LK_SCAN && (match ? exp_le : idx_end))
		|| (state_q == ttl_cache_pkg::ST_LK_WAIT && (!ov_q || m_tready));

	assign s_tready = (state_q == ttl_cache_pkg::ST_IDLE);
	assign m_tvalid = ov_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = OW'({o_rem_q, o_rec_q, o_rv_q, o_nx_q, o_hit_q});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttl_cache_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					unique case (in_func)
						ttl_cache_pkg::FUNC_STORE_POS:
							state_d = in_first ? ttl_cache_pkg::ST_SCAN_INV
								: ttl_cache_pkg::ST_APPEND;
						ttl_cache_pkg::FUNC_STORE_NEG: state_d = ttl_cache_pkg::ST_SCAN_INV;
						ttl_cache_pkg::FUNC_LOOKUP: state_d = ttl_cache_pkg::ST_LK_SCAN;
						default: state_d = ttl_cache_pkg::ST_IDLE;
					endcase
				end
			end
			ttl_cache_pkg::ST_SCAN_INV:
				if (!valid_q[idx_q]) state_d = ttl_cache_pkg::ST_START;
				else if (idx_end) state_d = ttl_cache_pkg::ST_SCAN_EXP;
			ttl_cache_pkg::ST_SCAN_EXP:
				if (exp_le) state_d = ttl_cache_pkg::ST_START;
				else if (idx_end) state_d = ttl_cache_pkg::ST_SCAN_MIN;
			ttl_cache_pkg::ST_SCAN_MIN:
				if (idx_end) state_d = ttl_cache_pkg::ST_START;
			ttl_cache_pkg::ST_START: state_d = ttl_cache_pkg::ST_APPEND;
			ttl_cache_pkg::ST_APPEND: state_d = ttl_cache_pkg::ST_IDLE;
			ttl_cache_pkg::ST_LK_SCAN:
				if (match) state_d = exp_le ? ttl_cache_pkg::ST_EMIT : ttl_cache_pkg::ST_LK_READ;
				else if (idx_end) state_d = ttl_cache_pkg::ST_EMIT;
			ttl_cache_pkg::ST_LK_READ: state_d = ttl_cache_pkg::ST_LK_WAIT;
			ttl_cache_pkg::ST_LK_WAIT:
				// once the output register is free: loop back through the memory while records remain, else emit
				if (!ov_q || m_tready) begin
					if (!eneg_q[idx_q] && n_q != '0 && rec_q + CW'(1) != n_q)
						state_d = ttl_cache_pkg::ST_LK_READ;
					else state_d = ttl_cache_pkg::ST_EMIT;
				end
			ttl_cache_pkg::ST_EMIT:
				if (!ov_q) state_d = ttl_cache_pkg::ST_IDLE;
			default: state_d = ttl_cache_pkg::ST_IDLE;
		endcase
	end

	// memory write port: appends and SOA saves
	logic [SW-1:0] ap_slot;
	logic ap_ok;
	assign ap_slot = (func_q == ttl_cache_pkg::FUNC_STORE_POS && !first_q) ? fill_q : slot_q;
	assign ap_ok = valid_q[ap_slot] && !eneg_q[ap_slot] && ecnt_q[ap_slot] < CW'(RECORDS_PER_ENTRY);
	always_comb begin
		mem_we = 1'b0;
		mem_wa = MW'(ap_slot) * MW'(RECORDS_PER_ENTRY) + MW'(ecnt_q[ap_slot]);
		mem_wd = data_q;
		if (state_q == ttl_cache_pkg::ST_APPEND) begin
			if (func_q == ttl_cache_pkg::FUNC_STORE_POS) mem_we = ap_ok;
			else begin
				mem_we = soa_q;
				mem_wa = MW'(slot_q) * MW'(RECORDS_PER_ENTRY);
			end
		end
		mem_ra = MW'(idx_q) * MW'(RECORDS_PER_ENTRY) + MW'(rec_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ttl_cache_pkg::ST_IDLE && s_tvalid) begin
			func_q <= in_func; key_q <= in_key; type_q <= in_type;
			now_q <= in_now; ttl_q <= in_ttl; data_q <= in_data;
			first_q <= in_first; soa_q <= in_soa;
		end
		if (state_q == ttl_cache_pkg::ST_START) begin
			ekey_q[slot_q] <= key_q;
			etype_q[slot_q] <= type_q;
			eexp_q[slot_q] <= {1'b0, now_q} + {1'b0, ttl_q};
			eneg_q[slot_q] <= (func_q == ttl_cache_pkg::FUNC_STORE_NEG);
			esoa_q[slot_q] <= 1'b0;
			ecnt_q[slot_q] <= '0;
		end
		if (state_q == ttl_cache_pkg::ST_APPEND) begin
			if (func_q == ttl_cache_pkg::FUNC_STORE_POS) begin
				if (ap_ok) ecnt_q[ap_slot] <= ecnt_q[ap_slot] + CW'(1);
			end else begin
				esoa_q[slot_q] <= soa_q;
			end
		end
		if (state_q == ttl_cache_pkg::ST_LK_SCAN && match) begin
			rem_q <= diff;
			n_q <= ecnt_q[idx_q];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttl_cache_pkg::ST_IDLE;
			valid_q <= '0;
			fill_q <= '0;
			idx_q <= '0; best_q <= '0; slot_q <= '0; rec_q <= '0;
			ov_q <= 1'b0; o_hit_q <= 1'b0; o_nx_q <= 1'b0; o_rv_q <= 1'b0;
			o_last_q <= 1'b0; o_rec_q <= '0; o_rem_q <= '0;
		end else begin
			state_q <= state_d;
			if (o_load) ov_q <= 1'b1;
			else if (ov_q && m_tready) ov_q <= 1'b0;
			unique case (state_q)
				ttl_cache_pkg::ST_IDLE: begin
					idx_q <= '0; best_q <= '0; rec_q <= '0;
				end
				ttl_cache_pkg::ST_SCAN_INV:
					if (!valid_q[idx_q]) slot_q <= idx_q;
					else idx_q <= idx_end ? '0 : idx_q + SW'(1);
				ttl_cache_pkg::ST_SCAN_EXP:
					if (exp_le) slot_q <= idx_q;
					else idx_q <= idx_end ? '0 : idx_q + SW'(1);
				ttl_cache_pkg::ST_SCAN_MIN: begin
					if (idx_end) slot_q <= (min_lt) ? idx_q : best_q;
					if (min_lt) best_q <= idx_q;
					idx_q <= idx_q + SW'(1);
				end
				ttl_cache_pkg::ST_START: begin
					valid_q[slot_q] <= 1'b1;
					fill_q <= slot_q;
				end
				ttl_cache_pkg::ST_LK_SCAN: begin
					if (match) begin
						if (exp_le) begin
							valid_q[idx_q] <= 1'b0;
							o_hit_q <= 1'b0; o_nx_q <= 1'b0; o_rv_q <= 1'b0;
							o_rec_q <= '0; o_rem_q <= '0; o_last_q <= 1'b1;
						end
					end else if (idx_end) begin
						o_hit_q <= 1'b0; o_nx_q <= 1'b0; o_rv_q <= 1'b0;
						o_rec_q <= '0; o_rem_q <= '0; o_last_q <= 1'b1;
					end else idx_q <= idx_q + SW'(1);
				end
				ttl_cache_pkg::ST_LK_READ: ;
				ttl_cache_pkg::ST_LK_WAIT:
					if (!ov_q || m_tready) begin
						o_hit_q <= 1'b1;
						o_rem_q <= rem_q[EB-1] ? '1 : rem_q[NB-1:0];
						if (eneg_q[idx_q]) begin
							o_nx_q <= 1'b1; o_rv_q <= esoa_q[idx_q];
							o_rec_q <= esoa_q[idx_q] ? rd_q : '0;
							o_last_q <= 1'b1;
							rec_q <= n_q;
						end else if (n_q == '0) begin
							o_nx_q <= 1'b0; o_rv_q <= 1'b0; o_rec_q <= '0;
							o_last_q <= 1'b1;
							rec_q <= n_q;
						end else begin
							o_nx_q <= 1'b0; o_rv_q <= 1'b1; o_rec_q <= rd_q;
							o_last_q <= (rec_q + CW'(1) == n_q);
							rec_q <= rec_q + CW'(1);
						end
					end
				ttl_cache_pkg::ST_EMIT: ;
				default: ;
			endcase
		end
	end
endmodule
